@@ rtl/sip_pkg.sv @@
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types and widths for the segment intersection point unit.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int DistW  = ProdW + 1;
  localparam int MagW   = ProdW;
  localparam int DenW   = MagW + 1;
  localparam int RemW   = DenW + 1;
  localparam int QuotW  = CoordW + 1;
  localparam int NumCells = QuotW;

  typedef struct packed {
    logic              incl;
    logic [CoordW-1:0] ax0;
    logic [CoordW-1:0] ay0;
    logic [CoordW-1:0] ax1;
    logic [CoordW-1:0] ay1;
    logic [CoordW-1:0] bx0;
    logic [CoordW-1:0] by0;
    logic [CoordW-1:0] bx1;
    logic [CoordW-1:0] by1;
  } sip_seg_t;

  typedef struct packed {
    logic             cand;
    sip_seg_t         seg;
    logic [DenW-1:0]  den;
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] q;
  } sip_div_t;

endpackage

@@ rtl/sip_front.sv @@
// ----------------------------------------------------------------------------
// sip_front
// Distances of segment two's endpoints to segment one's line, sign test,
// and set-up of the divider chain.
// ----------------------------------------------------------------------------
module sip_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  sip_pkg::sip_seg_t seg_i,
  output logic              valid_o,
  output sip_pkg::sip_div_t div_o
);
  import sip_pkg::*;

  logic [4:0] vld_q;

  sip_seg_t seg1_q, seg2_q, seg3_q, seg4_q;
  logic [DiffW-1:0] ex_q, ey_q, fx_q, fy_q, nx_q, ny_q;
  logic [ProdW-1:0] pex_q, pey_q, pfx_q, pfy_q;
  logic [DistW-1:0] d1_q, d2_q;
  logic [MagW-1:0]  m1_q, m2_q;
  logic             cand_q;
  sip_div_t         div_q;

  logic [ProdW-1:0] pex_d, pey_d, pfx_d, pfy_d;
  logic [DistW-1:0] nd1, nd2;
  logic             z1, z2, n1, n2;

  assign pex_d = $signed(ex_q) * $signed(nx_q);
  assign pey_d = $signed(ey_q) * $signed(ny_q);
  assign pfx_d = $signed(fx_q) * $signed(nx_q);
  assign pfy_d = $signed(fy_q) * $signed(ny_q);

  assign z1  = (d1_q == '0);
  assign z2  = (d2_q == '0);
  assign n1  = d1_q[DistW-1];
  assign n2  = d2_q[DistW-1];
  assign nd1 = DistW'(0) - d1_q;
  assign nd2 = DistW'(0) - d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg1_q <= seg_i;
      ex_q   <= {seg_i.bx0[CoordW-1], seg_i.bx0} - {seg_i.ax0[CoordW-1], seg_i.ax0};
      ey_q   <= {seg_i.by0[CoordW-1], seg_i.by0} - {seg_i.ay0[CoordW-1], seg_i.ay0};
      fx_q   <= {seg_i.bx1[CoordW-1], seg_i.bx1} - {seg_i.ax0[CoordW-1], seg_i.ax0};
      fy_q   <= {seg_i.by1[CoordW-1], seg_i.by1} - {seg_i.ay0[CoordW-1], seg_i.ay0};
      nx_q   <= {seg_i.ay0[CoordW-1], seg_i.ay0} - {seg_i.ay1[CoordW-1], seg_i.ay1};
      ny_q   <= {seg_i.ax1[CoordW-1], seg_i.ax1} - {seg_i.ax0[CoordW-1], seg_i.ax0};

      seg2_q <= seg1_q;
      pex_q  <= pex_d;
      pey_q  <= pey_d;
      pfx_q  <= pfx_d;
      pfy_q  <= pfy_d;

      seg3_q <= seg2_q;
      d1_q   <= {pex_q[ProdW-1], pex_q} + {pey_q[ProdW-1], pey_q};
      d2_q   <= {pfx_q[ProdW-1], pfx_q} + {pfy_q[ProdW-1], pfy_q};

      seg4_q <= seg3_q;
      m1_q   <= n1 ? nd1[MagW-1:0] : d1_q[MagW-1:0];
      m2_q   <= n2 ? nd2[MagW-1:0] : d2_q[MagW-1:0];
      cand_q <= !(z1 && z2) && !(!n1 && !z1 && !n2 && !z2) && !(n1 && n2);

      div_q.cand <= cand_q;
      div_q.seg  <= seg4_q;
      div_q.den  <= {1'b0, m1_q} + {1'b0, m2_q};
      div_q.rem  <= {2'b00, m2_q};
      div_q.q    <= '0;
    end
  end

  assign valid_o = vld_q[4];
  assign div_o   = div_q;

endmodule

@@ rtl/sip_div_cell.sv @@
// ----------------------------------------------------------------------------
// sip_div_cell
// One restoring division step: yields one quotient bit of lambda.
// ----------------------------------------------------------------------------
module sip_div_cell #(
  parameter bit First = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  sip_pkg::sip_div_t div_i,
  output logic              valid_o,
  output sip_pkg::sip_div_t div_o
);
  import sip_pkg::*;

  logic              vld_q;
  sip_div_t          div_q, div_d;
  logic [RemW-1:0]   sh;
  logic              ge;

  always_comb begin
    sh    = First ? div_i.rem : {div_i.rem[RemW-2:0], 1'b0};
    ge    = (sh >= {1'b0, div_i.den});
    div_d = div_i;
    div_d.rem = ge ? (sh - {1'b0, div_i.den}) : sh;
    div_d.q   = {div_i.q[QuotW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = vld_q;
  assign div_o   = div_q;

endmodule

@@ rtl/sip_back.sv @@
// ----------------------------------------------------------------------------
// sip_back
// Interpolation of the crossing point and bounding box test.
// ----------------------------------------------------------------------------
module sip_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  sip_pkg::sip_div_t         div_i,
  output logic                      valid_o,
  output logic                      hit_o,
  output logic [sip_pkg::CoordW-1:0] x_o,
  output logic [sip_pkg::CoordW-1:0] y_o
);
  import sip_pkg::*;

  localparam int OffW = CoordW + 3;
  localparam int SumW = ProdW + 1;

  logic [1:0]        vld_q;
  sip_seg_t          seg_q;
  logic              cand_q, negx_q, negy_q;
  logic [ProdW-1:0]  prx_q, pry_q;
  logic              hit_q;
  logic [CoordW-1:0] x_q, y_q;

  logic [DiffW-1:0]  dx, dy, mx, my;
  logic [SumW-1:0]   sx, sy;
  logic [OffW-1:0]   offx, offy, px, py;
  logic              okx, oky;

  function automatic logic in_box(input logic [CoordW-1:0] p, input logic [CoordW-1:0] e0,
                                  input logic [CoordW-1:0] e1, input logic incl);
    logic [CoordW-1:0] lo;
    logic [CoordW-1:0] hi;
    lo = ($signed(e0) < $signed(e1)) ? e0 : e1;
    hi = ($signed(e0) < $signed(e1)) ? e1 : e0;
    if (!($signed(lo) < $signed(hi))) begin
      return 1'b1;
    end
    if (incl) begin
      return ($signed(p) >= $signed(lo)) && ($signed(p) <= $signed(hi));
    end
    return ($signed(p) > $signed(lo)) && ($signed(p) < $signed(hi));
  endfunction

  assign dx = {div_i.seg.bx0[CoordW-1], div_i.seg.bx0} -
              {div_i.seg.bx1[CoordW-1], div_i.seg.bx1};
  assign dy = {div_i.seg.by0[CoordW-1], div_i.seg.by0} -
              {div_i.seg.by1[CoordW-1], div_i.seg.by1};
  assign mx = dx[DiffW-1] ? (DiffW'(0) - dx) : dx;
  assign my = dy[DiffW-1] ? (DiffW'(0) - dy) : dy;

  // ceil for the negative direction keeps the floor of the signed offset
  assign sx = {1'b0, prx_q} + SumW'(32'hFFFF_FFFF);
  assign sy = {1'b0, pry_q} + SumW'(32'hFFFF_FFFF);

  always_comb begin
    offx = negx_q ? (OffW'(0) - OffW'(sx[SumW-1:CoordW])) : OffW'(prx_q[ProdW-1:CoordW]);
    offy = negy_q ? (OffW'(0) - OffW'(sy[SumW-1:CoordW])) : OffW'(pry_q[ProdW-1:CoordW]);
    px   = {{(OffW-CoordW){seg_q.bx1[CoordW-1]}}, seg_q.bx1} + offx;
    py   = {{(OffW-CoordW){seg_q.by1[CoordW-1]}}, seg_q.by1} + offy;
    okx  = in_box(px[CoordW-1:0], seg_q.ax0, seg_q.ax1, seg_q.incl);
    oky  = in_box(py[CoordW-1:0], seg_q.ay0, seg_q.ay1, seg_q.incl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q  <= div_i.seg;
      cand_q <= div_i.cand;
      negx_q <= dx[DiffW-1];
      negy_q <= dy[DiffW-1];
      prx_q  <= div_i.q * mx;
      pry_q  <= div_i.q * my;

      hit_q  <= cand_q && okx && oky;
      x_q    <= (cand_q && okx && oky) ? px[CoordW-1:0] : '0;
      y_q    <= (cand_q && okx && oky) ? py[CoordW-1:0] : '0;
    end
  end

  assign valid_o = vld_q[1];
  assign hit_o   = hit_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

@@ rtl/segment_intersection_point_unit.sv @@
// The pipeline has 5 front stages, 33 divider cells and 2 back stages from input
// transfer to result. Throughput: one segment pair per cycle; the chain of
// restoring division cells yields one quotient bit per cell.
// The whole pipeline holds while a result waits on m_axis_tready.
// Reset (rst_ni low, asynchronous) clears all stage valid bits.
// ----------------------------------------------------------------------------
// segment_intersection_point_unit
// Crossing point of two 2-D Q16.16 segments, checked against segment one's box.
// ----------------------------------------------------------------------------
module segment_intersection_point_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [255:0] s_axis_tdata,
  // inclusive
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cross_x, cross_y
  output logic [63:0]  m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);
  import sip_pkg::*;

  logic     en;
  sip_seg_t seg_in;
  logic     chain_vld [NumCells+1];
  sip_div_t chain     [NumCells+1];
  logic [CoordW-1:0] x, y;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign seg_in.incl = s_axis_tuser;
  assign seg_in.ax0  = s_axis_tdata[31:0];
  assign seg_in.ay0  = s_axis_tdata[63:32];
  assign seg_in.ax1  = s_axis_tdata[95:64];
  assign seg_in.ay1  = s_axis_tdata[127:96];
  assign seg_in.bx0  = s_axis_tdata[159:128];
  assign seg_in.by0  = s_axis_tdata[191:160];
  assign seg_in.bx1  = s_axis_tdata[223:192];
  assign seg_in.by1  = s_axis_tdata[255:224];

  sip_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .seg_i   (seg_in),
    .valid_o (chain_vld[0]),
    .div_o   (chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    sip_div_cell #(
      .First (i == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_vld[i]),
      .div_i   (chain[i]),
      .valid_o (chain_vld[i+1]),
      .div_o   (chain[i+1])
    );
  end

  sip_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_vld[NumCells]),
    .div_i   (chain[NumCells]),
    .valid_o (m_axis_tvalid),
    .hit_o   (m_axis_tuser),
    .x_o     (x),
    .y_o     (y)
  );

  assign m_axis_tdata = {y, x};

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss result carries a nonzero point");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  a_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(chain_vld[NumCells]))
    else $error("divider chain moved during stall");

endmodule
